FILE: rtl/core/trace_event_correlation_table_defines.svh
// ----------------------------------------------------------------------------
// trace_event_correlation_table_defines
// Assertion macros shared by the correlation table files.
// ----------------------------------------------------------------------------
`ifndef TRACE_EVENT_CORRELATION_TABLE_DEFINES_SVH
`define TRACE_EVENT_CORRELATION_TABLE_DEFINES_SVH

// Check an implication at every clock edge outside reset.
`define TECT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent.
`define TECT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tect_pkg.sv
// ----------------------------------------------------------------------------
// tect_pkg
// Types and constants of the trace event correlation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tect_pkg;

  localparam int TIME_SLOTS = 5;

  localparam logic [5:0] ST_SEND_BEGIN = 6'd0;
  localparam logic [5:0] ST_SEND_END   = 6'd3;
  localparam logic [5:0] ST_RECV_BEGIN = 6'd8;
  localparam logic [5:0] ST_RECV_END   = 6'd12;

  localparam logic [1:0] RES_PHASE    = 2'd0;
  localparam logic [1:0] RES_DUP      = 2'd1;
  localparam logic [1:0] RES_NO_MATCH = 2'd2;
  localparam logic [1:0] RES_FULL     = 2'd3;

  typedef struct packed {
    logic [5:0]  event_state;
    logic [63:0] comm_id;
    logic [63:0] op_sequence;
    logic [7:0]  channel_number;
    logic [7:0]  step_number;
    logic [7:0]  peer_rank;
    logic [7:0]  collective_code;
    logic [31:0] byte_count;
    logic [63:0] step_sizes;
    logic [63:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] record_number;
    logic        is_send;
    logic [63:0] out_comm_id;
    logic [63:0] out_op_sequence;
    logic [31:0] op_tag;
    logic [31:0] out_byte_count;
    logic [63:0] out_step_sizes;
    logic [2:0]  phase_slot;
    logic [63:0] phase_time;
    logic        last_of_run;
  } out_item_t;

  // Key word: valid, written marks of slots 1..4, key.
  typedef struct packed {
    logic        valid;
    logic [3:0]  mask;
    logic [63:0] comm;
    logic [63:0] seq;
    logic [24:0] tag;
  } key_word_t;

  typedef struct packed {
    logic [7:0]  collective;
    logic [31:0] bytes;
    logic [63:0] sizes;
  } attr_word_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_RESOLVE, S_ERR, S_EMRD, S_EMLD
  } state_t;

endpackage

FILE: rtl/core/tect_ram.sv
// ----------------------------------------------------------------------------
// tect_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/trace_event_correlation_table.sv
// ----------------------------------------------------------------------------
// trace_event_correlation_table
// Pairs begin, phase and end trace events by key and emits finished records.
// ----------------------------------------------------------------------------
// Usage: events enter on in_valid/in_ready as one in_item beat; results
// leave on out_valid/out_ready as out_item beats. One event is worked on at
// a time. The table key store is searched one entry per cycle through its
// read port: a begin scans the whole table unless it meets a duplicate key,
// a phase or end event stops at its matching entry. An end event then emits
// 4 (send) or 5 (receive) beats; for each beat the time and attribute
// stores are read, then the output register is loaded. Errors give one beat.
// Ignored state codes are dropped on acceptance and in_ready stays high.
// After reset a clearing pass marks every entry free; in_ready stays low
// until it ends, and the record count is zero.
// When the receiver stalls the output beat holds in its register and the
// run pauses; a new event is taken only once the previous one is finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trace_event_correlation_table_defines.svh"

module trace_event_correlation_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tect_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tect_pkg::out_item_t out_item
);
  import tect_pkg::*;

  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int TD  = TABLE_ENTRIES * TIME_SLOTS;
  localparam int TAW = $clog2(TD);

  state_t state, state_next;

  in_item_t           item;
  logic               item_begin, item_send, item_end;
  logic [2:0]         item_slot;
  logic [24:0]        item_tag;

  logic [AW:0]        cnt;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  logic               found, free_found;
  logic [AW-1:0]      found_idx, free_idx;
  key_word_t          found_word;
  logic [1:0]         err_code;
  logic [2:0]         k;
  logic [63:0]        records;

  logic               key_we, key_re;
  logic [AW-1:0]      key_waddr, key_raddr;
  key_word_t          key_wdata, key_rdata;
  logic               attr_we, attr_re;
  logic [AW-1:0]      attr_waddr;
  attr_word_t         attr_wdata, attr_rdata;
  logic               time_we, time_re;
  logic [TAW-1:0]     time_waddr, time_raddr;
  logic [63:0]        time_wdata, time_rdata;

  logic               out_free, hit, scan_last, emit_last;
  logic [4:0]         written;
  logic [TAW-1:0]     found_base, free_base;

  tect_ram #(.WIDTH($bits(key_word_t)), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
  );
  tect_ram #(.WIDTH($bits(attr_word_t)), .DEPTH(TABLE_ENTRIES)) u_attr_ram (
    .clk, .we(attr_we), .waddr(attr_waddr), .wdata(attr_wdata),
    .re(attr_re), .raddr(found_idx), .rdata(attr_rdata)
  );
  tect_ram #(.WIDTH(64), .DEPTH(TD)) u_time_ram (
    .clk, .we(time_we), .waddr(time_waddr), .wdata(time_wdata),
    .re(time_re), .raddr(time_raddr), .rdata(time_rdata)
  );

  assign item_send  = item.event_state <= ST_SEND_END;
  assign item_begin = item.event_state == ST_SEND_BEGIN || item.event_state == ST_RECV_BEGIN;
  assign item_end   = item.event_state == ST_SEND_END || item.event_state == ST_RECV_END;
  assign item_slot  = item_send ? item.event_state[2:0] : 3'(item.event_state - ST_RECV_BEGIN);
  assign item_tag   = {item.channel_number, item.step_number, item.peer_rank, item_send};

  assign out_free   = !out_valid || out_ready;
  assign hit        = pend && key_rdata.valid && key_rdata.comm == item.comm_id &&
                      key_rdata.seq == item.op_sequence && key_rdata.tag == item_tag;
  assign scan_last  = pend_idx == AW'(TABLE_ENTRIES - 1);
  assign emit_last  = k == (item_send ? 3'd3 : 3'd4);
  assign written    = {found_word.mask, 1'b1};
  assign found_base = TAW'(found_idx) * TAW'(TIME_SLOTS);
  assign free_base  = TAW'(free_idx) * TAW'(TIME_SLOTS);
  assign in_ready   = state == S_IDLE;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (cnt == (AW+1)'(TABLE_ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.event_state inside {[ST_SEND_BEGIN:ST_SEND_END],
                                          [ST_RECV_BEGIN:ST_RECV_END]}) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: if (hit || (pend && scan_last)) state_next = S_RESOLVE;
      S_RESOLVE: begin
        if (item_begin) begin
          state_next = (found || !free_found) ? S_ERR : S_IDLE;
        end else if (!found) begin
          state_next = S_ERR;
        end else begin
          state_next = item_end ? S_EMRD : S_IDLE;
        end
      end
      S_ERR:  if (out_free) state_next = S_IDLE;
      S_EMRD: state_next = S_EMLD;
      S_EMLD: if (out_free) state_next = emit_last ? S_IDLE : S_EMRD;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    key_we     = 1'b0;
    key_waddr  = found_idx;
    key_wdata  = found_word;
    key_re     = 1'b0;
    key_raddr  = cnt[AW-1:0];
    attr_we    = 1'b0;
    attr_waddr = free_idx;
    attr_wdata = '{collective: item.collective_code, bytes: item.byte_count,
                   sizes: item.step_sizes};
    attr_re    = 1'b0;
    time_we    = 1'b0;
    time_waddr = found_base + TAW'(item_slot);
    time_wdata = item.event_time;
    time_re    = 1'b0;
    time_raddr = found_base + TAW'(k);
    case (state)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = cnt[AW-1:0];
        key_wdata = '0;
      end
      S_SCAN: key_re = !cnt[AW] && !hit;
      S_RESOLVE: begin
        if (item_begin) begin
          if (!found && free_found) begin
            key_we     = 1'b1;
            key_waddr  = free_idx;
            key_wdata  = '{valid: 1'b1, mask: 4'd0, comm: item.comm_id,
                           seq: item.op_sequence, tag: item_tag};
            attr_we    = 1'b1;
            time_we    = 1'b1;
            time_waddr = free_base;
          end
        end else if (found) begin
          key_we = 1'b1;
          if (item_end) begin
            key_wdata.valid = 1'b0;
          end else begin
            // mask bit n marks slot n + 1
            key_wdata.mask = found_word.mask | (4'b0001 << (item_slot - 3'd1));
            time_we        = 1'b1;
          end
        end
      end
      S_EMRD: begin
        time_re = 1'b1;
        attr_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      records   <= '0;
    end else begin
      state <= state_next;
      if ((state == S_ERR || state == S_EMLD) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          item       <= in_item;
          cnt        <= '0;
          pend       <= 1'b0;
          found      <= 1'b0;
          free_found <= 1'b0;
          k          <= '0;
        end
        S_SCAN: begin
          pend     <= key_re;
          pend_idx <= cnt[AW-1:0];
          if (key_re) cnt <= cnt + 1'b1;
          if (hit) begin
            found      <= 1'b1;
            found_idx  <= pend_idx;
            found_word <= key_rdata;
          end else if (pend && !key_rdata.valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= pend_idx;
          end
        end
        S_RESOLVE: begin
          // error code only matters on the error path
          if (item_begin) err_code <= found ? RES_DUP : RES_FULL;
          else            err_code <= RES_NO_MATCH;
          // written mark of the end slot does not matter: it is substituted
        end
        S_ERR: begin
          if (out_free) begin
            out_item <= '{status: err_code, last_of_run: 1'b1, default: '0};
          end
        end
        S_EMLD: begin
          if (out_free) begin
            out_item <= '{status:          RES_PHASE,
                          record_number:   records,
                          is_send:         item_send,
                          out_comm_id:     found_word.comm,
                          out_op_sequence: found_word.seq,
                          op_tag:          {found_word.tag[24:1], attr_rdata.collective},
                          out_byte_count:  attr_rdata.bytes,
                          out_step_sizes:  attr_rdata.sizes,
                          phase_slot:      k,
                          phase_time:      (k == item_slot) ? item.event_time :
                                           (written[k] ? time_rdata : 64'd0),
                          last_of_run:     emit_last};
            k <= k + 1'b1;
            if (emit_last) records <= records + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `TECT_ASSERT_NEXT(a_one_at_a_time, state == S_IDLE && state_next == S_SCAN, !in_ready, "second event taken")
  `TECT_ASSERT_IMP(a_err_last, out_valid && out_item.status != RES_PHASE,
    out_item.last_of_run, "error beat not last")
  `TECT_ASSERT_IMP(a_slot_range, out_valid && out_item.status == RES_PHASE,
    out_item.phase_slot <= 3'd4, "phase slot out of range")
  `TECT_ASSERT_IMP(a_no_write_in_scan, state == S_SCAN, !key_we && !time_we,
    "table written during search")

endmodule
